// ----- hdl/psnp_pkg.sv -----
`timescale 1ns / 1ps

package psnp_pkg;

    localparam int REQ_TYPE_W = 3;
    localparam int NODE_IDX_W = 9;
    localparam int POS_W      = 16;
    localparam int COST_W     = 24;
    localparam int CLOSED_W   = 16;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_INIT     = 3'd0,
        REQ_CREATE   = 3'd1,
        REQ_GET_BEST = 3'd2,
        REQ_CLOSE    = 3'd3,
        REQ_REOPEN   = 3'd4,
        REQ_LOOKUP   = 3'd5
    } req_code_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RMW,
        ST_RESP
    } state_t;

    // One pool entry as held in the node memory
    typedef struct packed {
        logic [POS_W-1:0]      x;
        logic [POS_W-1:0]      y;
        logic [COST_W-1:0]     cost;
        logic [NODE_IDX_W-1:0] parent;
        logic                  has_parent;
        logic                  open;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    typedef struct packed {
        logic                  ok;
        logic [NODE_IDX_W-1:0] index;
        logic [POS_W-1:0]      x;
        logic [POS_W-1:0]      y;
        logic [COST_W-1:0]     cost;
        logic                  has_parent;
        logic [NODE_IDX_W-1:0] parent;
    } result_t;

    typedef struct packed {
        logic start;
        logic take;
        logic lookup;
    } scan_ctl_t;

endpackage

// ----- hdl/psnp_if.sv -----
`timescale 1ns / 1ps

interface psnp_req_if;
    logic                                valid;
    logic                                ready;
    logic [psnp_pkg::REQ_TYPE_W-1:0]     req_type;
    logic [psnp_pkg::NODE_IDX_W-1:0]     node_index;
    logic [psnp_pkg::POS_W-1:0]          pos_x;
    logic [psnp_pkg::POS_W-1:0]          pos_y;
    logic [psnp_pkg::COST_W-1:0]         cost;
    logic [psnp_pkg::NODE_IDX_W-1:0]     parent_index;

    modport source (output valid, req_type, node_index, pos_x, pos_y, cost, parent_index,
                    input ready);
    modport sink   (input valid, req_type, node_index, pos_x, pos_y, cost, parent_index,
                    output ready);
endinterface

interface psnp_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic [psnp_pkg::NODE_IDX_W-1:0]     out_index;
    logic [psnp_pkg::POS_W-1:0]          out_x;
    logic [psnp_pkg::POS_W-1:0]          out_y;
    logic [psnp_pkg::COST_W-1:0]         out_cost;
    logic                                has_parent;
    logic [psnp_pkg::NODE_IDX_W-1:0]     out_parent;
    logic [psnp_pkg::CLOSED_W-1:0]       closed_total;

    modport source (output valid, ok, out_index, out_x, out_y, out_cost, has_parent,
                    out_parent, closed_total, input ready);
    modport sink   (input valid, ok, out_index, out_x, out_y, out_cost, has_parent,
                    out_parent, closed_total, output ready);
endinterface

// ----- hdl/psnp_ram.sv -----
`timescale 1ns / 1ps

module psnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/psnp_scan.sv -----
`timescale 1ns / 1ps

module psnp_scan #(
    parameter int IDX_W = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  psnp_pkg::scan_ctl_t            ctl,
    input  logic [IDX_W-1:0]               rd_idx,
    input  logic [psnp_pkg::NODE_W-1:0]    rd_data,
    input  logic [psnp_pkg::POS_W-1:0]     key_x,
    input  logic [psnp_pkg::POS_W-1:0]     key_y,
    output logic                           found,
    output logic [IDX_W-1:0]               best_idx,
    output psnp_pkg::node_t                lead_node
);

    psnp_pkg::node_t  rd_node;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    psnp_pkg::node_t  best_reg;
    logic             hit_lookup;
    logic             hit_best;
    logic             hit;

    assign rd_node    = psnp_pkg::node_t'(rd_data);
    assign hit_lookup = (rd_node.x == key_x) && (rd_node.y == key_y);
    // strict compare: on equal cost the earlier (lower) index stays
    assign hit_best   = rd_node.open && (!found_reg || (rd_node.cost < best_reg.cost));
    assign hit        = ctl.lookup ? hit_lookup : hit_best;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.take && hit)
        begin
            found_reg <= 1'b1;
        end
    end

    // ascending scan: a later match overrides, so lookup ends on the newest node
    always_ff @(posedge clk)
    begin
        if (ctl.take && hit)
        begin
            best_idx_reg <= rd_idx;
            best_reg     <= rd_node;
        end
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign lead_node = best_reg;

endmodule

// ----- hdl/path_search_node_pool.sv -----
`timescale 1ns / 1ps

// Node pool for a best-first path search.
// Requests arrive on the req channel (init, create, get best, close, reopen,
// lookup by position); each one gives exactly one transaction on rsp.
// One request is worked on at a time; req.ready is high only while the
// block is idle, and it may take the next request while the previous
// result still waits in the rsp output register.
// Close and reopen do a read-modify-write of the node memory (skipped when
//   the index is out of range); get best and lookup read the node memory,
//   one node memory read per cycle over the used nodes; init runs a sweep,
//   one entry per cycle, that clears every entry and writes the start node
//   to entry zero.
// After reset a sweep clears every entry with req.ready low.
// When rsp is stalled the result holds in its register; a finished request
// whose result cannot be stored waits, and req.ready stays low until then.
module path_search_node_pool #(
    parameter int POOL_NODES = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    psnp_req_if.sink      req,
    psnp_rsp_if.source    rsp
);

    localparam int IDX_W = $clog2(POOL_NODES);
    localparam int CNT_W = $clog2(POOL_NODES + 1);
    localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(POOL_NODES - 1);
    localparam logic [CNT_W-1:0] POOL_CNT  = CNT_W'(POOL_NODES);

    psnp_pkg::state_t                state_reg, state_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [CNT_W-1:0]                used_reg, used_next;
    logic [psnp_pkg::CLOSED_W-1:0]   closed_reg, closed_next;
    logic                            init_clear_reg, init_clear_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]                rd_idx_reg, rd_idx_next;
    psnp_pkg::result_t               res_reg, res_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    psnp_pkg::result_t               rsp_data_reg, rsp_data_next;
    logic [psnp_pkg::CLOSED_W-1:0]   rsp_closed_reg, rsp_closed_next;

    logic [psnp_pkg::REQ_TYPE_W-1:0] q_type_reg;
    logic [psnp_pkg::NODE_IDX_W-1:0] q_index_reg;
    logic [psnp_pkg::POS_W-1:0]      q_x_reg;
    logic [psnp_pkg::POS_W-1:0]      q_y_reg;
    logic [psnp_pkg::COST_W-1:0]     q_cost_reg;
    logic [psnp_pkg::NODE_IDX_W-1:0] q_parent_reg;

    logic                            req_ready;
    logic                            index_ok;
    psnp_pkg::req_code_t             q_code;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    psnp_pkg::node_t                 ram_wdata;
    logic [IDX_W-1:0]                ram_raddr;
    logic [psnp_pkg::NODE_W-1:0]     ram_rdata;
    psnp_pkg::node_t                 rd_node;

    psnp_pkg::scan_ctl_t             scan_ctl;
    logic                            scan_found;
    logic [IDX_W-1:0]                scan_best_idx;
    psnp_pkg::node_t                 scan_lead_node;

    psnp_ram #(
        .WIDTH (psnp_pkg::NODE_W),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    psnp_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .rd_idx    (rd_idx_reg),
        .rd_data   (ram_rdata),
        .key_x     (q_x_reg),
        .key_y     (q_y_reg),
        .found     (scan_found),
        .best_idx  (scan_best_idx),
        .lead_node (scan_lead_node)
    );

    assign rd_node  = psnp_pkg::node_t'(ram_rdata);
    assign q_code   = psnp_pkg::req_code_t'(q_type_reg);
    assign index_ok = 32'(q_index_reg) < 32'(POOL_NODES);

    assign req.ready = req_ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.ok           = rsp_data_reg.ok;
    assign rsp.out_index    = rsp_data_reg.index;
    assign rsp.out_x        = rsp_data_reg.x;
    assign rsp.out_y        = rsp_data_reg.y;
    assign rsp.out_cost     = rsp_data_reg.cost;
    assign rsp.has_parent   = rsp_data_reg.has_parent;
    assign rsp.out_parent   = rsp_data_reg.parent;
    assign rsp.closed_total = rsp_closed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= psnp_pkg::ST_CLEAR;
            cnt_reg        <= '0;
            used_reg       <= '0;
            closed_reg     <= '0;
            init_clear_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            used_reg       <= used_next;
            closed_reg     <= closed_next;
            init_clear_reg <= init_clear_next;
            rd_pend_reg    <= rd_pend_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        res_reg        <= res_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_closed_reg <= rsp_closed_next;
        if (req.valid && req_ready)
        begin
            q_type_reg   <= req.req_type;
            q_index_reg  <= req.node_index;
            q_x_reg      <= req.pos_x;
            q_y_reg      <= req.pos_y;
            q_cost_reg   <= req.cost;
            q_parent_reg <= req.parent_index;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        closed_next     = closed_reg;
        init_clear_next = init_clear_reg;
        rd_pend_next    = rd_pend_reg;
        rd_idx_next     = rd_idx_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_closed_next = rsp_closed_reg;
        req_ready       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[IDX_W-1:0];
        ram_wdata       = '0;
        ram_raddr       = cnt_reg[IDX_W-1:0];
        scan_ctl        = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            psnp_pkg::ST_CLEAR:
            begin
                // sweep every entry closed; on init, entry zero becomes the start node
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[IDX_W-1:0];
                if (init_clear_reg && (cnt_reg == '0))
                begin
                    ram_wdata.x    = q_x_reg;
                    ram_wdata.y    = q_y_reg;
                    ram_wdata.open = 1'b1;
                end
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next = '0;
                    if (init_clear_reg)
                    begin
                        init_clear_next = 1'b0;
                        used_next       = CNT_W'(1);
                        closed_next     = '0;
                        res_next        = '0;
                        res_next.ok     = 1'b1;
                        state_next      = psnp_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = psnp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            psnp_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    state_next = psnp_pkg::ST_EXEC;
                end
            end

            psnp_pkg::ST_EXEC:
            begin
                res_next   = '0;
                state_next = psnp_pkg::ST_RESP;
                case (q_code)
                    psnp_pkg::REQ_INIT:
                    begin
                        init_clear_next = 1'b1;
                        cnt_next        = '0;
                        state_next      = psnp_pkg::ST_CLEAR;
                    end
                    psnp_pkg::REQ_CREATE:
                    begin
                        if (used_reg < POOL_CNT)
                        begin
                            ram_we               = 1'b1;
                            ram_waddr            = used_reg[IDX_W-1:0];
                            ram_wdata.x          = q_x_reg;
                            ram_wdata.y          = q_y_reg;
                            ram_wdata.cost       = q_cost_reg;
                            ram_wdata.parent     = q_parent_reg;
                            ram_wdata.has_parent = 1'b1;
                            ram_wdata.open       = 1'b1;
                            used_next            = used_reg + CNT_W'(1);
                            res_next.ok          = 1'b1;
                            res_next.index       = psnp_pkg::NODE_IDX_W'(used_reg);
                        end
                    end
                    psnp_pkg::REQ_GET_BEST, psnp_pkg::REQ_LOOKUP:
                    begin
                        cnt_next       = '0;
                        rd_pend_next   = 1'b0;
                        scan_ctl.start = 1'b1;
                        state_next     = psnp_pkg::ST_SCAN;
                    end
                    psnp_pkg::REQ_CLOSE, psnp_pkg::REQ_REOPEN:
                    begin
                        if (index_ok)
                        begin
                            ram_raddr  = IDX_W'(q_index_reg);
                            state_next = psnp_pkg::ST_RMW;
                        end
                    end
                    default:
                    begin
                        state_next = psnp_pkg::ST_RESP;
                    end
                endcase
            end

            psnp_pkg::ST_SCAN:
            begin
                scan_ctl.lookup = (q_code == psnp_pkg::REQ_LOOKUP);
                scan_ctl.take   = rd_pend_reg;
                if (cnt_reg < used_reg)
                begin
                    ram_raddr    = cnt_reg[IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        res_next = '0;
                        if (scan_found)
                        begin
                            res_next.ok    = 1'b1;
                            res_next.index = psnp_pkg::NODE_IDX_W'(scan_best_idx);
                            if (q_code != psnp_pkg::REQ_LOOKUP)
                            begin
                                res_next.x          = scan_lead_node.x;
                                res_next.y          = scan_lead_node.y;
                                res_next.cost       = scan_lead_node.cost;
                                res_next.has_parent = scan_lead_node.has_parent;
                                res_next.parent     = scan_lead_node.parent;
                            end
                        end
                        state_next = psnp_pkg::ST_RESP;
                    end
                end
            end

            psnp_pkg::ST_RMW:
            begin
                ram_we      = 1'b1;
                ram_waddr   = IDX_W'(q_index_reg);
                ram_wdata   = rd_node;
                res_next.ok = 1'b1;
                if (q_code == psnp_pkg::REQ_CLOSE)
                begin
                    ram_wdata.open = 1'b0;
                    closed_next    = closed_reg + psnp_pkg::CLOSED_W'(1);
                end
                else
                begin
                    ram_wdata.cost       = q_cost_reg;
                    ram_wdata.parent     = q_parent_reg;
                    ram_wdata.has_parent = 1'b1;
                    ram_wdata.open       = 1'b1;
                    if (!rd_node.open)
                    begin
                        closed_next = closed_reg - psnp_pkg::CLOSED_W'(1);
                    end
                end
                state_next = psnp_pkg::ST_RESP;
            end

            psnp_pkg::ST_RESP:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_data_next   = res_reg;
                    rsp_closed_next = closed_reg;
                    state_next      = psnp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = psnp_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= POOL_CNT)
        else $error("node count beyond pool size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second request taken while one is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == psnp_pkg::ST_SCAN) && scan_found) |->
            (CNT_W'(scan_best_idx) < used_reg))
        else $error("scan result outside the used nodes");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psnp_pkg::ST_SCAN) |-> !ram_we)
        else $error("node memory written during a scan");

endmodule

// ----- dv/tb_path_search_node_pool.sv -----
`timescale 1ns / 1ps

module tb_path_search_node_pool;

    localparam int REQ_TYPE_W  = psnp_pkg::REQ_TYPE_W;
    localparam int NODE_IDX_W  = psnp_pkg::NODE_IDX_W;
    localparam int POS_W       = psnp_pkg::POS_W;
    localparam int COST_W      = psnp_pkg::COST_W;
    localparam int CLOSED_W    = psnp_pkg::CLOSED_W;

    localparam int POOL_NODES  = 512;
    localparam int ITEM_TARGET = 1170;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = POOL_NODES + 64;

    // Request codes the block does not know
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [NODE_IDX_W-1:0] idx;
        logic [POS_W-1:0]      x;
        logic [POS_W-1:0]      y;
        logic [COST_W-1:0]     cost;
        logic [NODE_IDX_W-1:0] par;
    } pool_req_t;

    typedef struct packed {
        logic                  ok;
        logic [NODE_IDX_W-1:0] idx;
        logic [POS_W-1:0]      x;
        logic [POS_W-1:0]      y;
        logic [COST_W-1:0]     cost;
        logic                  has_par;
        logic [NODE_IDX_W-1:0] par;
        logic [CLOSED_W-1:0]   closed;
    } pool_rsp_t;

    typedef struct {
        pool_req_t r;
        bit        typed;
        pool_rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    psnp_req_if req();
    psnp_rsp_if rsp();

    // Shadow copy of the pool
    bit [POS_W-1:0]      node_x     [POOL_NODES];
    bit [POS_W-1:0]      node_y     [POOL_NODES];
    bit [COST_W-1:0]     node_cost  [POOL_NODES];
    bit [NODE_IDX_W-1:0] node_par   [POOL_NODES];
    bit                  node_haspar[POOL_NODES];
    bit                  node_open  [POOL_NODES];
    int                  pool_used = 0;
    bit [CLOSED_W-1:0]   closed_cnt = '0;

    pool_rsp_t rsp_expected[$];
    pool_rsp_t rsp_seen;
    pool_rsp_t rsp_want;
    dir_row_t  dir_tab[$];
    int        err_cnt = 0;
    int        cycle_cnt = 0;
    int        idle_pct = 8;

    path_search_node_pool #(
        .POOL_NODES (POOL_NODES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic pool_req_t mk_req(input logic [REQ_TYPE_W-1:0] kind,
                                         input logic [NODE_IDX_W-1:0] idx,
                                         input logic [POS_W-1:0] x,
                                         input logic [POS_W-1:0] y,
                                         input logic [COST_W-1:0] cost,
                                         input logic [NODE_IDX_W-1:0] par);
        pool_req_t r;
        r.kind = kind;
        r.idx  = idx;
        r.x    = x;
        r.y    = y;
        r.cost = cost;
        r.par  = par;
        return r;
    endfunction

    function automatic pool_rsp_t mk_rsp(input logic ok, input logic [NODE_IDX_W-1:0] idx,
                                         input logic [POS_W-1:0] x,
                                         input logic [POS_W-1:0] y,
                                         input logic [COST_W-1:0] cost,
                                         input logic has_par,
                                         input logic [NODE_IDX_W-1:0] par,
                                         input logic [CLOSED_W-1:0] closed);
        pool_rsp_t o;
        o.ok      = ok;
        o.idx     = idx;
        o.x       = x;
        o.y       = y;
        o.cost    = cost;
        o.has_par = has_par;
        o.par     = par;
        o.closed  = closed;
        return o;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input pool_req_t r, input bit typed, input pool_rsp_t want);
        dir_row_t row;
        row.r     = r;
        row.typed = typed;
        row.want  = want;
        dir_tab   = {dir_tab, row};
    endtask

    function automatic pool_req_t rand_req(input logic [REQ_TYPE_W-1:0] kind);
        return mk_req(kind, NODE_IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      COST_W'($urandom), NODE_IDX_W'($urandom));
    endfunction

    function automatic void store_node(input int i, input pool_req_t r, input bit with_par);
        node_x[i]      = r.x;
        node_y[i]      = r.y;
        node_cost[i]   = with_par ? r.cost : '0;
        node_par[i]    = with_par ? r.par : '0;
        node_haspar[i] = with_par;
        node_open[i]   = 1'b1;
    endfunction

    // Apply one request to the shadow pool and return the result it gives
    function automatic pool_rsp_t pool_apply(input pool_req_t r);
        pool_rsp_t res;
        int        best;
        int        k;
        bit        found;
        res   = '0;
        best  = 0;
        found = 1'b0;
        case (r.kind)
            psnp_pkg::REQ_INIT:
            begin
                foreach (node_open[j])
                    node_open[j] = 1'b0;
                closed_cnt = '0;
                store_node(0, r, 1'b0);
                pool_used = 1;
                res.ok = 1'b1;
            end
            psnp_pkg::REQ_CREATE:
            begin
                if (pool_used < POOL_NODES)
                begin
                    store_node(pool_used, r, 1'b1);
                    res.ok  = 1'b1;
                    res.idx = NODE_IDX_W'(pool_used);
                    pool_used++;
                end
            end
            psnp_pkg::REQ_GET_BEST:
            begin
                // strict less-than keeps the lowest index on equal cost
                for (k = 0; k < pool_used; k++)
                begin
                    if (node_open[k] && (!found || node_cost[k] < node_cost[best]))
                    begin
                        found = 1'b1;
                        best  = k;
                    end
                end
                if (found)
                begin
                    res.ok      = 1'b1;
                    res.idx     = NODE_IDX_W'(best);
                    res.x       = node_x[best];
                    res.y       = node_y[best];
                    res.cost    = node_cost[best];
                    res.has_par = node_haspar[best];
                    res.par     = node_par[best];
                end
            end
            psnp_pkg::REQ_CLOSE:
            begin
                if (r.idx < POOL_NODES)
                begin
                    node_open[r.idx] = 1'b0;
                    closed_cnt++;
                    res.ok = 1'b1;
                end
            end
            psnp_pkg::REQ_REOPEN:
            begin
                if (r.idx < POOL_NODES)
                begin
                    node_cost[r.idx]   = r.cost;
                    node_par[r.idx]    = r.par;
                    node_haspar[r.idx] = 1'b1;
                    if (!node_open[r.idx])
                    begin
                        node_open[r.idx] = 1'b1;
                        closed_cnt--;
                    end
                    res.ok = 1'b1;
                end
            end
            psnp_pkg::REQ_LOOKUP:
            begin
                // newest match wins: walk down from the top
                for (k = pool_used - 1; k >= 0; k--)
                begin
                    if (node_x[k] == r.x && node_y[k] == r.y)
                    begin
                        res.ok  = 1'b1;
                        res.idx = NODE_IDX_W'(k);
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.closed = closed_cnt;
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input pool_req_t r, input bit typed, input pool_rsp_t want);
        pool_rsp_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.req_type     <= r.kind;
        req.node_index   <= r.idx;
        req.pos_x        <= r.x;
        req.pos_y        <= r.y;
        req.cost         <= r.cost;
        req.parent_index <= r.par;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predicted    = pool_apply(r);
        rsp_expected = {rsp_expected, (typed ? want : predicted)};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(negedge clk);
        while (rsp_expected.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        rsp.ready <= ($urandom_range(0, 99) >= idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            rsp_seen = {rsp.ok, rsp.out_index, rsp.out_x, rsp.out_y, rsp.out_cost,
                        rsp.has_parent, rsp.out_parent, rsp.closed_total};
            if (rsp_expected.size() == 0)
                flag_error("result transaction with nothing expected");
            else
            begin
                rsp_want = rsp_expected.pop_front();
                check_field("ok", 24'(rsp_seen.ok), 24'(rsp_want.ok));
                check_field("out_index", 24'(rsp_seen.idx), 24'(rsp_want.idx));
                check_field("out_x", 24'(rsp_seen.x), 24'(rsp_want.x));
                check_field("out_y", 24'(rsp_seen.y), 24'(rsp_want.y));
                check_field("out_cost", rsp_seen.cost, rsp_want.cost);
                check_field("has_parent", 24'(rsp_seen.has_par), 24'(rsp_want.has_par));
                check_field("out_parent", 24'(rsp_seen.par), 24'(rsp_want.par));
                check_field("closed_total", 24'(rsp_seen.closed), 24'(rsp_want.closed));
            end
        end
    end

    initial
    begin
        pool_req_t r;
        int        items_sent;
        int        episode;
        int        grow_to;
        int        span;
        int        pick;
        int        j;
        int        k;
        bit        fill;

        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.req_type     = '0;
        req.node_index   = '0;
        req.pos_x        = '0;
        req.pos_y        = '0;
        req.cost         = '0;
        req.parent_index = '0;
        items_sent       = 0;

        // Directed rows: typed results where they are obvious, the rest predicted
        add_row(mk_req(psnp_pkg::REQ_GET_BEST, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(psnp_pkg::REQ_LOOKUP, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(psnp_pkg::REQ_CREATE, 0, 16'h1234, 16'h5678, 24'd100, 9'd7),
                1'b1, mk_rsp(1, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_SPARE_6, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_SPARE_7, 9'h1FF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 9'h1FF), 1'b1,
                mk_rsp(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(psnp_pkg::REQ_INIT, 0, 16'hFFFF, 16'h0, 0, 0), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(psnp_pkg::REQ_CREATE, 0, 16'h0, 16'hFFFF, 24'hFFFFFF, 9'h1FF),
                1'b1, mk_rsp(1, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(psnp_pkg::REQ_CREATE, 0, 16'hFFFF, 16'h0, 0, 0), 1'b1,
                mk_rsp(1, 2, 0, 0, 0, 0, 0, 0));
        // equal cost on nodes 0 and 2: the lower index wins
        add_row(mk_req(psnp_pkg::REQ_GET_BEST, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 0, 16'hFFFF, 16'h0, 0, 0, 0, 0));
        // same position on nodes 0 and 2: the newer wins
        add_row(mk_req(psnp_pkg::REQ_LOOKUP, 0, 16'hFFFF, 16'h0, 0, 0), 1'b1,
                mk_rsp(1, 2, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(psnp_pkg::REQ_CLOSE, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(psnp_pkg::REQ_GET_BEST, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 2, 16'hFFFF, 16'h0, 0, 1, 0, 1));
        add_row(mk_req(psnp_pkg::REQ_CLOSE, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 2));
        add_row(mk_req(psnp_pkg::REQ_REOPEN, 1, 0, 0, 0, 9'h155), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 2));
        add_row(mk_req(psnp_pkg::REQ_CLOSE, 2, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 3));
        add_row(mk_req(psnp_pkg::REQ_GET_BEST, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 1, 16'h0, 16'hFFFF, 0, 1, 9'h155, 3));
        add_row(mk_req(psnp_pkg::REQ_REOPEN, 2, 0, 0, 24'hFFFFFF, 9'h0AA), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 2));
        // node above the used count is accepted but not scanned
        add_row(mk_req(psnp_pkg::REQ_REOPEN, 9'h1FF, 0, 0, 24'd5, 9'd3), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(psnp_pkg::REQ_LOOKUP, 0, 16'h1, 16'h1, 0, 0), 1'b1,
                mk_rsp(0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(psnp_pkg::REQ_INIT, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 0));
        // closed count wraps below zero, then back up
        add_row(mk_req(psnp_pkg::REQ_REOPEN, 2, 0, 0, 24'd1, 9'd1), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        add_row(mk_req(psnp_pkg::REQ_CLOSE, 2, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(psnp_pkg::REQ_GET_BEST, 0, 0, 0, 0, 0), 1'b1,
                mk_rsp(1, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(psnp_pkg::REQ_CREATE, 0, 16'hAAAA, 16'h5555, 24'h800000, 9'h1FF),
                1'b0, '0);
        add_row(mk_req(psnp_pkg::REQ_GET_BEST, 0, 0, 0, 0, 0), 1'b0, '0);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            send_req(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].want);
            items_sent++;
        end
        // hold off until the pool has answered everything
        wait_drained();

        episode = 0;
        while (items_sent < ITEM_TARGET)
        begin
            fill     = (episode == 2);
            idle_pct = (episode >= 4 && episode < 9) ? 0 : 8;
            r = rand_req(psnp_pkg::REQ_INIT);
            send_req(r, 1'b0, '0);
            items_sent++;
            if (fill)
            begin
                // fill the pool and run past the top so creates are refused
                for (k = 0; k < POOL_NODES + 2; k++)
                begin
                    r = rand_req(psnp_pkg::REQ_CREATE);
                    send_req(r, 1'b0, '0);
                    items_sent++;
                end
            end
            grow_to = fill ? POOL_NODES + 3 : $urandom_range(1, 40);
            span    = fill ? 12 : $urandom_range(10, 60);
            for (k = 0; k < span && items_sent < ITEM_TARGET; k++)
            begin
                pick = $urandom_range(0, 99);
                r.par = NODE_IDX_W'($urandom);
                if (pool_used > 0 && $urandom_range(0, 99) < 85)
                    r.idx = NODE_IDX_W'($urandom_range(0, pool_used - 1));
                else
                    r.idx = NODE_IDX_W'($urandom_range(0, POOL_NODES - 1));
                if ($urandom_range(0, 99) < 40)
                begin
                    r.x = POS_W'($urandom_range(0, 3));
                    r.y = POS_W'($urandom_range(0, 3));
                end
                else
                begin
                    r.x = POS_W'($urandom);
                    r.y = POS_W'($urandom);
                end
                j = $urandom_range(0, 99);
                if (j < 40)
                    r.cost = COST_W'($urandom_range(0, 7));
                else if (j < 45)
                    r.cost = 24'hFFFFFF;
                else
                    r.cost = COST_W'($urandom);
                if (pick < 5)
                    r.kind = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
                else if (pick < 8)
                    r.kind = psnp_pkg::REQ_INIT;
                else if (pick < 33)
                    r.kind = (pool_used < grow_to) ? psnp_pkg::REQ_CREATE
                                                   : psnp_pkg::REQ_GET_BEST;
                else if (pick < 53)
                    r.kind = psnp_pkg::REQ_GET_BEST;
                else if (pick < 70)
                    r.kind = psnp_pkg::REQ_CLOSE;
                else if (pick < 83)
                    r.kind = psnp_pkg::REQ_REOPEN;
                else
                    r.kind = psnp_pkg::REQ_LOOKUP;
                // mostly look up positions that exist
                if (r.kind == psnp_pkg::REQ_LOOKUP && pool_used > 0
                    && $urandom_range(0, 99) < 60)
                begin
                    j   = $urandom_range(0, pool_used - 1);
                    r.x = node_x[j];
                    r.y = node_y[j];
                end
                send_req(r, 1'b0, '0);
                items_sent++;
            end
            if ($urandom_range(0, 2) == 0)
                wait_drained();
            episode++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (rsp_expected.size() != 0)
            flag_error($sformatf("%0d results never arrived", rsp_expected.size()));
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- path_search_node_pool.f -----
hdl/psnp_pkg.sv
hdl/psnp_if.sv
hdl/psnp_ram.sv
hdl/psnp_scan.sv
hdl/path_search_node_pool.sv
dv/tb_path_search_node_pool.sv
